>>> rtl/core/block_map_first_fit_allocator_macros.svh
// Assertion macros for the checker file.
`ifndef BLOCK_MAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BLOCK_MAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BMFFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bmffa same-cycle check failed");

// Next-cycle implication, held off during reset.
`define BMFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bmffa next-cycle check failed");

`endif

>>> rtl/core/bmffa_pkg.sv
package bmffa_pkg;

    localparam int BLOCK_COUNT_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int BYTES_W  = 16;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 11;
    localparam int TAG_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } t_opcode;

    typedef enum logic [TAG_W-1:0] {
        TAG_FREE = 2'd0,
        TAG_HEAD = 2'd1,
        TAG_CONT = 2'd2
    } t_tag;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOT_INIT = 3'd1,
        ST_BAD_SIZE = 3'd2,
        ST_NO_SPACE = 3'd3,
        ST_BAD_ADDR = 3'd4
    } t_status;

endpackage

>>> rtl/core/bmffa_ram.sv
module bmffa_ram #(
    parameter int WIDTH = bmffa_pkg::TAG_W,
    parameter int DEPTH = bmffa_pkg::BLOCK_COUNT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/block_map_first_fit_allocator.sv
// First-fit block map allocator. One command is taken when start is high and busy is low;
// exactly one result follows, shown for one cycle with o_strobe, and cannot be held off.
// The block tags sit in a one-read, one-write RAM that is walked entry by entry: after reset
// a clearing pass over every entry keeps busy high; init runs the same pass with busy high;
// allocate scans for the first run of free blocks that covers the request, then tags the
// head block and each continuation block of the grant; free walks the block bases to the
// block holding the offset and clears it, then reads and clears each continuation block in
// turn, and reads the tag that ends the run. The result shows in the first cycle with busy
// low. Rejected commands and unused opcodes answer on the next cycle and leave busy low.
module block_map_first_fit_allocator #(
    parameter int BLOCK_COUNT = bmffa_pkg::BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = bmffa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bmffa_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [bmffa_pkg::BYTES_W-1:0]     i_request_bytes,
    input  logic [bmffa_pkg::BYTES_W-1:0]     i_release_offset,
    output logic                              o_strobe,
    output logic [bmffa_pkg::STATUS_W-1:0]    o_status,
    output logic [bmffa_pkg::GRANT_W-1:0]     o_grant_offset
);

    localparam int IDX_W      = $clog2(BLOCK_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int HEAP_TOTAL = BLOCK_COUNT * BLOCK_BYTES;
    localparam int HEAP_W     = $clog2(HEAP_TOTAL + 1);
    localparam int W          = (HEAP_W > bmffa_pkg::BYTES_W) ? HEAP_W + 1
                                                             : bmffa_pkg::BYTES_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(BLOCK_COUNT - 1);
    localparam logic [CNT_W-1:0] LIMIT      = CNT_W'(BLOCK_COUNT);
    localparam logic [W-1:0]     HEAP_LIMIT = W'(HEAP_TOTAL);
    localparam logic [W-1:0]     BB         = W'(BLOCK_BYTES);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CLEAR    = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_MARK     = 7'b0001000,
        S_FIND     = 7'b0010000,
        S_FREE_RD  = 7'b0100000,
        S_FREE_CHK = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_report, n_report;
    logic             r_armed, n_armed;
    logic             r_dv, n_dv;
    logic             r_strobe, n_strobe;

    logic [IDX_W-1:0]                r_didx, n_didx;
    logic [IDX_W-1:0]                r_head, n_head;
    logic [IDX_W-1:0]                r_end, n_end;
    logic [W-1:0]                    r_run, n_run;
    logic [W-1:0]                    r_base, n_base;
    logic [bmffa_pkg::BYTES_W-1:0]   r_bytes, n_bytes;
    logic [bmffa_pkg::BYTES_W-1:0]   r_off, n_off;
    bmffa_pkg::t_status              r_status, n_status;
    logic [bmffa_pkg::GRANT_W-1:0]   r_grant, n_grant;

    logic                         w_we;
    logic [IDX_W-1:0]             w_waddr;
    bmffa_pkg::t_tag              w_wdata;
    logic [bmffa_pkg::TAG_W-1:0]  w_rdata;
    logic                         w_accept;
    logic [IDX_W-1:0]             w_idx;
    logic [W-1:0]                 w_run_next;
    logic [W-1:0]                 w_base_next;
    logic [W-1:0]                 w_grant_full;
    logic [W-1:0]                 w_req_ext;
    logic [W-1:0]                 w_off_ext;

    bmffa_ram #(
        .WIDTH (bmffa_pkg::TAG_W),
        .DEPTH (BLOCK_COUNT)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_idx       = r_addr[IDX_W-1:0];
    assign w_run_next  = r_run + BB;
    assign w_base_next = r_base + BB;
    assign w_req_ext   = W'(i_request_bytes);
    assign w_off_ext   = W'(r_off);
    assign w_grant_full = W'(r_head) * BB;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_report = r_report;
        n_armed  = r_armed;
        n_dv     = r_dv;
        n_strobe = 1'b0;
        n_didx   = r_didx;
        n_head   = r_head;
        n_end    = r_end;
        n_run    = r_run;
        n_base   = r_base;
        n_bytes  = r_bytes;
        n_off    = r_off;
        n_status = r_status;
        n_grant  = r_grant;
        w_we     = 1'b0;
        w_waddr  = w_idx;
        w_wdata  = bmffa_pkg::TAG_FREE;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bytes  = i_request_bytes;
                    n_off    = i_release_offset;
                    n_grant  = '0;
                    n_status = bmffa_pkg::ST_OK;
                    case (i_opcode)
                        bmffa_pkg::OP_INIT: begin
                            n_state  = S_CLEAR;
                            n_addr   = '0;
                            n_report = 1'b1;
                        end
                        bmffa_pkg::OP_ALLOC: begin
                            if (!r_armed) begin
                                n_strobe = 1'b1;
                                n_status = bmffa_pkg::ST_NOT_INIT;
                            end else if (i_request_bytes == '0 || w_req_ext > HEAP_LIMIT) begin
                                n_strobe = 1'b1;
                                n_status = bmffa_pkg::ST_BAD_SIZE;
                            end else begin
                                n_state = S_SCAN;
                                n_addr  = '0;
                                n_dv    = 1'b0;
                                n_run   = '0;
                                n_head  = '0;
                            end
                        end
                        bmffa_pkg::OP_FREE: begin
                            if (!r_armed) begin
                                n_strobe = 1'b1;
                                n_status = bmffa_pkg::ST_NOT_INIT;
                            end else if (W'(i_release_offset) >= HEAP_LIMIT) begin
                                n_strobe = 1'b1;
                                n_status = bmffa_pkg::ST_BAD_ADDR;
                            end else begin
                                n_state = S_FIND;
                                n_addr  = '0;
                                n_base  = '0;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                w_we = 1'b1;
                if (w_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                    if (r_report) begin
                        n_strobe = 1'b1;
                        n_armed  = 1'b1;
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SCAN: begin
                // issue the next read while the previous tag is examined
                if (r_addr != LIMIT) begin
                    n_addr = r_addr + 1'b1;
                    n_dv   = 1'b1;
                    n_didx = w_idx;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (w_rdata == bmffa_pkg::TAG_FREE) begin
                        if (w_run_next >= W'(r_bytes)) begin
                            n_end   = r_didx;
                            n_addr  = CNT_W'(r_head);
                            n_state = S_MARK;
                        end else begin
                            n_run = w_run_next;
                        end
                    end else begin
                        n_run  = '0;
                        n_head = r_didx + 1'b1;
                    end
                end else if (r_addr == LIMIT) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_status = bmffa_pkg::ST_NO_SPACE;
                end
            end
            S_MARK: begin
                w_we    = 1'b1;
                w_wdata = (w_idx == r_head) ? bmffa_pkg::TAG_HEAD : bmffa_pkg::TAG_CONT;
                if (w_idx == r_end) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_grant  = w_grant_full[bmffa_pkg::GRANT_W-1:0];
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FIND: begin
                // walk block bases until the one holding the offset
                if (w_off_ext < w_base_next) begin
                    w_we = 1'b1;
                    if (w_idx == LAST_IDX) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = S_FREE_RD;
                    end
                end else begin
                    n_base = w_base_next;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (w_rdata == bmffa_pkg::TAG_CONT) begin
                    w_we = 1'b1;
                    if (w_idx == LAST_IDX) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = S_FREE_RD;
                    end
                end else begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_report <= 1'b0;
            r_armed  <= 1'b0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_report <= n_report;
            r_armed  <= n_armed;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx   <= n_didx;
        r_head   <= n_head;
        r_end    <= n_end;
        r_run    <= n_run;
        r_base   <= n_base;
        r_bytes  <= n_bytes;
        r_off    <= n_off;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_grant_offset = r_grant;

endmodule

>>> rtl/core/bmffa_checker.sv
`include "block_map_first_fit_allocator_macros.svh"

module bmffa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [bmffa_pkg::OPCODE_W-1:0] i_opcode,
    input logic [bmffa_pkg::BYTES_W-1:0]  i_request_bytes,
    input logic [bmffa_pkg::BYTES_W-1:0]  i_release_offset,
    input logic                           o_strobe,
    input logic [bmffa_pkg::STATUS_W-1:0] o_status,
    input logic [bmffa_pkg::GRANT_W-1:0]  o_grant_offset
);

    // a transfer either answers at once or keeps the block busy
    `BMFFA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_strobe)

    // a result closes the operation
    `BMFFA_ASSERT_SAME(a_strobe_not_busy, i_clk, i_rst_n, o_strobe, !busy)

    // only a granted allocation carries an offset
    `BMFFA_ASSERT_SAME(a_grant_zero_on_error, i_clk, i_rst_n,
        o_strobe && o_status != bmffa_pkg::ST_OK, o_grant_offset == '0)

    // an operation that runs on in the map gives no result while busy
    `BMFFA_ASSERT_NEXT(a_no_result_while_busy, i_clk, i_rst_n, busy && $past(busy), !$past(o_strobe) || !busy || o_strobe == 1'b0)

endmodule

bind block_map_first_fit_allocator bmffa_checker u_bmffa_checker (.*);
